// ----- hw/rtl/cted_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cted_pkg
// Shared constants, codes and types for the capped transposition edit
// distance block.
// ----------------------------------------------------------------------------
package cted_pkg;

	// string store depth and derived widths
	localparam int MAX_LEN = 128;
	localparam int ADDR_W  = $clog2(MAX_LEN);
	localparam int LEN_W   = 8;
	localparam int CHAR_W  = 8;

	// cap handling
	localparam logic [LEN_W-1:0] CAP_LIMIT = LEN_W'(128);
	localparam logic [LEN_W-1:0] SHORT_LEN = LEN_W'(4);
	localparam logic [LEN_W-1:0] CAP_SHORT = LEN_W'(1);
	localparam logic [LEN_W-1:0] CAP_LONG  = LEN_W'(2);
	localparam logic [LEN_W-1:0] COUNT_MAX = LEN_W'(255);

	// item mode codes
	localparam logic [1:0] MODE_FIRST   = 2'd0;
	localparam logic [1:0] MODE_SECOND  = 2'd1;
	localparam logic [1:0] MODE_COMPUTE = 2'd2;

	// configuration register indexes
	localparam logic CFG_SUGGEST   = 1'b0;
	localparam logic CFG_FIXED_CAP = 1'b1;

	// neighbour costs presented to the cell unit
	typedef struct packed {
		logic [LEN_W-1:0] up;
		logic [LEN_W-1:0] left;
		logic [LEN_W-1:0] diag;
		logic [LEN_W-1:0] two;
		logic             mismatch;
		logic             swap;
	} cell_in_t;

endpackage

// ----- hw/rtl/cted_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cted_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module cted_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ----- hw/rtl/cted_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cted_cell
// Shared cost unit: one alignment cell from its up, left, diagonal and
// two-back diagonal neighbours.
// ----------------------------------------------------------------------------
module cted_cell
	import cted_pkg::*;
(
	input  cell_in_t         cin,
	output logic [LEN_W-1:0] cost
);

	logic [LEN_W-1:0] del_c;
	logic [LEN_W-1:0] ins_c;
	logic [LEN_W-1:0] sub_c;
	logic [LEN_W-1:0] swp_c;
	logic [LEN_W-1:0] m1;

	// candidate costs
	assign del_c = cin.up + LEN_W'(1);
	assign ins_c = cin.left + LEN_W'(1);
	assign sub_c = cin.diag + LEN_W'(cin.mismatch);
	assign swp_c = cin.two + LEN_W'(1);

	// minimum, transposition only where allowed
	always_comb begin
		m1 = (ins_c < del_c) ? ins_c : del_c;
		if (sub_c < m1) begin
			m1 = sub_c;
		end
		if (cin.swap && (swp_c < m1)) begin
			m1 = swp_c;
		end
		cost = m1;
	end

endmodule

// ----- hw/rtl/capped_transposition_edit_distance_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// capped_transposition_edit_distance_top
// Capped optimal string alignment distance between two loaded byte strings.
// ----------------------------------------------------------------------------
// Usage:
//   input channel (in_valid / in_stall, mode, char_in): mode 0 appends
//   char_in to the first string, mode 1 to the second, mode 2 starts a
//   compare; mode 3 is taken and dropped. A compare item runs the
//   alignment one cell per cycle through a single cost unit, reading the
//   two previous rows and the second string from RAM. The row walk is skipped
//   when a length, length gap or empty string settles the answer. in_stall
//   is high for the whole compare. One item (distance, is_suggestion)
//   leaves on the output channel; it sits in an output register, so loads
//   for the next pair are taken while it waits. A compare that finishes
//   while the previous result is still stalled holds until that result is
//   taken. Both strings are emptied when a compare is taken. Reset empties
//   the strings and sets suggestion mode with a fixed cap of 2; no clearing
//   pass is needed.
// ----------------------------------------------------------------------------
module capped_transposition_edit_distance_top
	import cted_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	// configuration
	input  logic              cfg_we,
	input  logic              cfg_index,
	input  logic [LEN_W-1:0]  cfg_data,
	// input items
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [1:0]        mode,
	input  logic [CHAR_W-1:0] char_in,
	// result items
	output logic              out_valid,
	input  logic              out_stall,
	output logic [LEN_W-1:0]  distance,
	output logic              is_suggestion
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SETUP,
		ST_ROW_RD,
		ST_ROW_INIT,
		ST_WALK,
		ST_ROW_END,
		ST_FINISH
	} state_t;

	typedef logic [1:0] buf_sel_t;

	state_t           state_q;
	logic             suggest_q;
	logic [LEN_W-1:0] fixed_cap_q;
	logic [LEN_W-1:0] first_count_q;
	logic [LEN_W-1:0] second_count_q;
	logic [LEN_W-1:0] alen_q;
	logic [LEN_W-1:0] blen_q;
	logic [LEN_W-1:0] cap_q;
	logic [LEN_W-1:0] res_q;
	logic [LEN_W-1:0] row_q;
	logic [LEN_W-1:0] col_q;
	buf_sel_t         now_sel_q;
	buf_sel_t         back_sel_q;
	buf_sel_t         two_sel_q;
	logic             out_valid_q;
	logic [LEN_W-1:0] distance_q;
	logic             is_suggestion_q;

	// datapath registers of the row walk
	logic [LEN_W-1:0]  left_q;
	logic [LEN_W-1:0]  diag_q;
	logic [LEN_W-1:0]  tba_q;
	logic [LEN_W-1:0]  tbb_q;
	logic [LEN_W-1:0]  row_min_q;
	logic [LEN_W-1:0]  last_cell_q;
	logic [CHAR_W-1:0] ca_q;
	logic [CHAR_W-1:0] ca_prev_q;
	logic [CHAR_W-1:0] cb_prev_q;

	logic              in_take;
	logic              load_first;
	logic              load_second;
	logic              take_compute;
	logic [LEN_W-1:0]  cap_new;
	logic [LEN_W-1:0]  gap;
	logic [LEN_W-1:0]  cap_plus;
	logic              too_long;
	logic              out_free;
	logic              finish_go;
	logic              sugg;
	logic [ADDR_W-1:0] rd_addr;
	logic [ADDR_W-1:0] row_waddr;
	logic [ADDR_W-1:0] ft_raddr;
	logic [CHAR_W-1:0] ft_rd;
	logic [CHAR_W-1:0] st_rd;
	logic [LEN_W-1:0]  row_rd [3];
	logic [LEN_W-1:0]  back_val;
	logic [LEN_W-1:0]  two_val;
	logic [LEN_W-1:0]  cell_cost;
	cell_in_t          cell_in;

	// input handshake and item decode
	assign in_stall     = (state_q != ST_IDLE);
	assign in_take      = in_valid && !in_stall;
	assign load_first   = in_take && (mode == MODE_FIRST);
	assign load_second  = in_take && (mode == MODE_SECOND);
	assign take_compute = in_take && (mode == MODE_COMPUTE);

	// cap for the compare about to start
	always_comb begin
		if (suggest_q) begin
			cap_new = (first_count_q < SHORT_LEN) ? CAP_SHORT : CAP_LONG;
		end else begin
			cap_new = (fixed_cap_q > CAP_LIMIT) ? CAP_LIMIT : fixed_cap_q;
		end
	end

	// early-out checks on the latched lengths
	assign gap      = (alen_q > blen_q) ? (alen_q - blen_q) : (blen_q - alen_q);
	assign too_long = (alen_q > LEN_W'(MAX_LEN)) || (blen_q > LEN_W'(MAX_LEN));
	assign cap_plus = cap_q + LEN_W'(1);

	// string stores
	cted_ram #(.WIDTH(CHAR_W), .DEPTH(MAX_LEN)) u_first_text (
		.clk   (clk),
		.we    (load_first && (first_count_q < LEN_W'(MAX_LEN))),
		.waddr (first_count_q[ADDR_W-1:0]),
		.wdata (char_in),
		.raddr (ft_raddr),
		.rdata (ft_rd)
	);

	cted_ram #(.WIDTH(CHAR_W), .DEPTH(MAX_LEN)) u_second_text (
		.clk   (clk),
		.we    (load_second && (second_count_q < LEN_W'(MAX_LEN))),
		.waddr (second_count_q[ADDR_W-1:0]),
		.wdata (char_in),
		.raddr (rd_addr),
		.rdata (st_rd)
	);

	// read addresses: next column during the walk, column one at row start
	assign ft_raddr  = ADDR_W'(row_q - LEN_W'(1));
	assign rd_addr   = (state_q == ST_WALK) ? col_q[ADDR_W-1:0] : '0;
	assign row_waddr = ADDR_W'(col_q - LEN_W'(1));

	// three rotating row buffers, column j kept at address j-1
	for (genvar k = 0; k < 3; k++) begin : g_row
		cted_ram #(.WIDTH(LEN_W), .DEPTH(MAX_LEN)) u_row (
			.clk   (clk),
			.we    ((state_q == ST_WALK) && (now_sel_q == buf_sel_t'(k))),
			.waddr (row_waddr),
			.wdata (cell_cost),
			.raddr (rd_addr),
			.rdata (row_rd[k])
		);
	end

	// row zero is j itself and is never stored
	assign back_val = (row_q == LEN_W'(1)) ? col_q : row_rd[back_sel_q];
	assign two_val  = (row_q == LEN_W'(2)) ? col_q : row_rd[two_sel_q];

	// neighbours for the shared cost unit
	always_comb begin
		cell_in.up       = back_val;
		cell_in.left     = left_q;
		cell_in.diag     = diag_q;
		cell_in.two      = tbb_q;
		cell_in.mismatch = (ca_q != st_rd);
		cell_in.swap     = (row_q > LEN_W'(1)) && (col_q > LEN_W'(1)) &&
			(ca_q == cb_prev_q) && (ca_prev_q == st_rd);
	end

	cted_cell u_cell (
		.cin  (cell_in),
		.cost (cell_cost)
	);

	// result qualification
	assign out_free  = !out_valid_q || !out_stall;
	assign finish_go = (state_q == ST_FINISH) && out_free;
	assign sugg      = (alen_q != '0) && (blen_q != '0) && (res_q <= cap_q) &&
		(res_q != '0);

	// sequencer, counts, configuration and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			suggest_q       <= 1'b1;
			fixed_cap_q     <= LEN_W'(2);
			first_count_q   <= '0;
			second_count_q  <= '0;
			alen_q          <= '0;
			blen_q          <= '0;
			cap_q           <= '0;
			res_q           <= '0;
			row_q           <= '0;
			col_q           <= '0;
			now_sel_q       <= buf_sel_t'(0);
			back_sel_q      <= buf_sel_t'(1);
			two_sel_q       <= buf_sel_t'(2);
			out_valid_q     <= 1'b0;
			distance_q      <= '0;
			is_suggestion_q <= 1'b0;
		end else begin
			// configuration writes
			if (cfg_we) begin
				case (cfg_index)
					CFG_SUGGEST:   suggest_q   <= cfg_data[0];
					CFG_FIXED_CAP: fixed_cap_q <= cfg_data;
					default:       suggest_q   <= suggest_q;
				endcase
			end

			// output register: new item loaded or waiting item taken
			if (finish_go) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end

			// string loads
			if (load_first && (first_count_q != COUNT_MAX)) begin
				first_count_q <= first_count_q + LEN_W'(1);
			end
			if (load_second && (second_count_q != COUNT_MAX)) begin
				second_count_q <= second_count_q + LEN_W'(1);
			end

			case (state_q)
				ST_IDLE: begin
					if (take_compute) begin
						alen_q         <= first_count_q;
						blen_q         <= second_count_q;
						cap_q          <= cap_new;
						first_count_q  <= '0;
						second_count_q <= '0;
						state_q        <= ST_SETUP;
					end
				end
				ST_SETUP: begin
					row_q      <= LEN_W'(1);
					now_sel_q  <= buf_sel_t'(0);
					back_sel_q <= buf_sel_t'(1);
					two_sel_q  <= buf_sel_t'(2);
					if (too_long || (gap > cap_q)) begin
						res_q   <= cap_plus;
						state_q <= ST_FINISH;
					end else if (alen_q == '0) begin
						res_q   <= blen_q;
						state_q <= ST_FINISH;
					end else if (blen_q == '0) begin
						res_q   <= alen_q;
						state_q <= ST_FINISH;
					end else begin
						state_q <= ST_ROW_RD;
					end
				end
				ST_ROW_RD: begin
					state_q <= ST_ROW_INIT;
				end
				ST_ROW_INIT: begin
					col_q   <= LEN_W'(1);
					state_q <= ST_WALK;
				end
				ST_WALK: begin
					if (col_q == blen_q) begin
						state_q <= ST_ROW_END;
					end else begin
						col_q <= col_q + LEN_W'(1);
					end
				end
				ST_ROW_END: begin
					if (row_min_q > cap_q) begin
						res_q   <= cap_plus;
						state_q <= ST_FINISH;
					end else if (row_q == alen_q) begin
						res_q   <= last_cell_q;
						state_q <= ST_FINISH;
					end else begin
						row_q      <= row_q + LEN_W'(1);
						two_sel_q  <= back_sel_q;
						back_sel_q <= now_sel_q;
						now_sel_q  <= two_sel_q;
						state_q    <= ST_ROW_RD;
					end
				end
				ST_FINISH: begin
					if (out_free) begin
						distance_q      <= res_q;
						is_suggestion_q <= sugg;
						state_q         <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// row walk datapath
	always_ff @(posedge clk) begin
		if (state_q == ST_ROW_INIT) begin
			ca_q      <= ft_rd;
			ca_prev_q <= ca_q;
			left_q    <= row_q;
			diag_q    <= row_q - LEN_W'(1);
			tba_q     <= row_q - LEN_W'(2);
			row_min_q <= row_q;
		end else if (state_q == ST_WALK) begin
			left_q      <= cell_cost;
			diag_q      <= back_val;
			tbb_q       <= tba_q;
			tba_q       <= two_val;
			cb_prev_q   <= st_rd;
			last_cell_q <= cell_cost;
			if (cell_cost < row_min_q) begin
				row_min_q <= cell_cost;
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign distance      = distance_q;
	assign is_suggestion = is_suggestion_q;

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the capped transposition edit distance block.
// Loads pairs of byte strings, runs compares under several cap settings and
// checks each distance and suggestion flag against an in-bench predictor,
// with random gaps on the input side and random stalls on the result side.
// ----------------------------------------------------------------------------
module tb;
	import cted_pkg::*;

	localparam logic [1:0] MODE_IGNORED  = 2'd3;
	localparam int         SETTLE_CYCLES = 8;
	localparam int         CYCLE_LIMIT   = 1_000_000;

	typedef struct {
		logic [LEN_W-1:0] exp_dist;
		logic             sugg;
	} score_t;

	logic              clk;
	logic              arst_n;
	logic              cfg_we;
	logic              cfg_index;
	logic [LEN_W-1:0]  cfg_data;
	logic              in_valid;
	logic              in_stall;
	logic [1:0]        mode;
	logic [CHAR_W-1:0] char_in;
	logic              out_valid;
	logic              out_stall;
	logic [LEN_W-1:0]  distance;
	logic              is_suggestion;

	// shadow copy of the block state
	logic [CHAR_W-1:0] first_shadow [0:MAX_LEN-1];
	logic [CHAR_W-1:0] second_shadow [0:MAX_LEN-1];
	logic [LEN_W-1:0]  first_len   = '0;
	logic [LEN_W-1:0]  second_len  = '0;
	logic              suggest_on  = 1'b1;
	logic [LEN_W-1:0]  cap_setting = LEN_W'(2);

	score_t awaited_scores [$];

	int idle_pct         = 0;
	int stall_pct        = 0;
	int mismatches       = 0;
	int results_checked  = 0;
	int items_taken      = 0;
	int settings_applied = 0;
	int cycle_count      = 0;

	logic [LEN_W-1:0] cap_sweep [0:7] = '{8'd0, 8'd1, 8'd2, 8'd3, 8'd127, 8'd128, 8'd129, 8'd255};
	int phase_idle [0:3] = '{0, 50, 0, 35};
	int phase_stall [0:3] = '{0, 0, 50, 35};

	capped_transposition_edit_distance_top i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.mode          (mode),
		.char_in       (char_in),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.distance      (distance),
		.is_suggestion (is_suggestion)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// run guard
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("run exceeded %0d cycles, %0d results still awaited",
				CYCLE_LIMIT, awaited_scores.size());
			$display("tb NOT OK");
			$finish;
		end
	end

	task automatic flag_mismatch(string what);
		$display("[%0t] mismatch: %s", $time, what);
		mismatches++;
	endtask

	// restricted damerau distance with early give-up beyond the cap
	function automatic int capped_osa(int alen, int blen, int cap);
		int row_two [0:MAX_LEN];
		int row_prev [0:MAX_LEN];
		int row_cur [0:MAX_LEN];
		int best;
		int row_min;
		int cost;
		if (alen > MAX_LEN || blen > MAX_LEN)
			return cap + 1;
		if (((alen > blen) ? alen - blen : blen - alen) > cap)
			return cap + 1;
		for (int j = 0; j <= blen; j++) begin
			row_prev[j] = j;
			row_two[j] = 0;
		end
		for (int i = 1; i <= alen; i++) begin
			row_min = i;
			row_cur[0] = i;
			for (int j = 1; j <= blen; j++) begin
				best = row_prev[j] + 1;
				if (row_cur[j-1] + 1 < best)
					best = row_cur[j-1] + 1;
				cost = (first_shadow[i-1] == second_shadow[j-1]) ? 0 : 1;
				if (row_prev[j-1] + cost < best)
					best = row_prev[j-1] + cost;
				// swap of two neighbouring characters
				if (i > 1 && j > 1 && first_shadow[i-1] == second_shadow[j-2] &&
						first_shadow[i-2] == second_shadow[j-1] &&
						row_two[j-2] + 1 < best)
					best = row_two[j-2] + 1;
				row_cur[j] = best;
				if (best < row_min)
					row_min = best;
			end
			if (row_min > cap)
				return cap + 1;
			row_two = row_prev;
			row_prev = row_cur;
		end
		return row_prev[blen];
	endfunction

	// update the shadow state for one accepted item
	function automatic void apply_item(logic [1:0] m, logic [CHAR_W-1:0] c);
		score_t s;
		int cap;
		int d;
		bit same;
		case (m)
			MODE_FIRST: begin
				if (first_len < MAX_LEN)
					first_shadow[first_len] = c;
				if (first_len != COUNT_MAX)
					first_len++;
			end
			MODE_SECOND: begin
				if (second_len < MAX_LEN)
					second_shadow[second_len] = c;
				if (second_len != COUNT_MAX)
					second_len++;
			end
			MODE_COMPUTE: begin
				if (suggest_on)
					cap = (first_len < SHORT_LEN) ? CAP_SHORT : CAP_LONG;
				else
					cap = (cap_setting > CAP_LIMIT) ? CAP_LIMIT : cap_setting;
				d = capped_osa(first_len, second_len, cap);
				s.exp_dist = d[LEN_W-1:0];
				s.sugg = first_len != 0 && second_len != 0 && d <= cap;
				// identical strings are never a suggestion
				if (s.sugg && first_len == second_len && first_len <= MAX_LEN) begin
					same = 1'b1;
					for (int k = 0; k < first_len; k++)
						if (first_shadow[k] != second_shadow[k])
							same = 1'b0;
					if (same)
						s.sugg = 1'b0;
				end
				awaited_scores.push_back(s);
				first_len = '0;
				second_len = '0;
			end
			default: ;
		endcase
	endfunction

	// offer one item, idling first at random, and wait until it is taken
	task automatic offer_item(logic [1:0] m, logic [CHAR_W-1:0] c);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		mode <= m;
		char_in <= c;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		if (m != MODE_IGNORED)
			items_taken++;
		apply_item(m, c);
	endtask

	// wait for every awaited result, then let the block go quiet
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (awaited_scores.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// write both registers; only called while the block is quiet
	task automatic configure(logic sugg, logic [LEN_W-1:0] cap);
		logic [LEN_W-1:0] junk;
		junk = LEN_W'($urandom);
		cfg_we <= 1'b1;
		cfg_index <= CFG_SUGGEST;
		cfg_data <= {junk[LEN_W-1:1], sugg};
		@(posedge clk);
		cfg_index <= CFG_FIXED_CAP;
		cfg_data <= cap;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		suggest_on = sugg;
		cap_setting = cap;
		settings_applied++;
	endtask

	task automatic load_text(logic [1:0] which, string s);
		for (int k = 0; k < s.len(); k++)
			offer_item(which, s[k]);
	endtask

	function automatic logic [CHAR_W-1:0] rand_char(bit narrow);
		return narrow ? CHAR_W'(8'h61 + $urandom_range(3)) : CHAR_W'($urandom_range(255));
	endfunction

	// build a pair (second string edited from the first, or unrelated when
	// blen is not negative), load it interleaved and compare
	task automatic send_pair(int alen, int blen, int edits, bit narrow);
		logic [CHAR_W-1:0] s1 [$];
		logic [CHAR_W-1:0] s2 [$];
		logic [CHAR_W-1:0] t;
		int ia;
		int ib;
		int pos;
		for (int k = 0; k < alen; k++)
			s1.push_back(rand_char(narrow));
		if (blen >= 0) begin
			for (int k = 0; k < blen; k++)
				s2.push_back(rand_char(narrow));
		end else begin
			s2 = s1;
			repeat (edits) begin
				case ((s2.size() == 0) ? 2 : $urandom_range(3))
					0: begin
						pos = $urandom_range(s2.size() - 1);
						s2[pos] = rand_char(narrow);
					end
					1: s2.delete($urandom_range(s2.size() - 1));
					2: s2.insert($urandom_range(s2.size()), rand_char(narrow));
					default: begin
						if (s2.size() >= 2) begin
							pos = $urandom_range(s2.size() - 2);
							t = s2[pos];
							s2[pos] = s2[pos+1];
							s2[pos+1] = t;
						end
					end
				endcase
			end
		end
		ia = 0;
		ib = 0;
		while (ia < s1.size() || ib < s2.size()) begin
			if ($urandom_range(99) < 3)
				offer_item(MODE_IGNORED, rand_char(1'b0));
			if (ib >= s2.size() || (ia < s1.size() && $urandom_range(1))) begin
				offer_item(MODE_FIRST, s1[ia]);
				ia++;
			end else begin
				offer_item(MODE_SECOND, s2[ib]);
				ib++;
			end
		end
		offer_item(MODE_COMPUTE, rand_char(1'b0));
	endtask

	task automatic random_pair();
		int sel;
		sel = $urandom_range(99);
		if (sel < 65)
			send_pair($urandom_range(8), -1, $urandom_range(3), 1'($urandom_range(1)));
		else if (sel < 85)
			send_pair($urandom_range(6), $urandom_range(6), 0, 1'($urandom_range(1)));
		else if (sel < 93)
			send_pair($urandom_range(24, 9), -1, $urandom_range(4), 1'($urandom_range(1)));
		else
			// loose items of any mode; loose loads fold into the next pair
			repeat ($urandom_range(3, 1))
				offer_item(2'($urandom_range(3)), CHAR_W'($urandom_range(255)));
	endtask

	function automatic logic [LEN_W-1:0] pick_cap();
		case ($urandom_range(5))
			0: return 8'd0;
			1: return 8'd1;
			2: return 8'd2;
			3: return 8'd128;
			4: return 8'd255;
			default: return LEN_W'($urandom_range(255));
		endcase
	endfunction

	// corner cases under the reset settings
	task automatic test_directed();
		idle_pct = 0;
		stall_pct = 0;
		// two empty strings
		offer_item(MODE_COMPUTE, 8'h00);
		// neighbour swap at the byte extremes, unused mode code in between
		offer_item(MODE_FIRST, 8'h00);
		offer_item(MODE_IGNORED, 8'hFF);
		offer_item(MODE_FIRST, 8'hFF);
		offer_item(MODE_SECOND, 8'hFF);
		offer_item(MODE_SECOND, 8'h00);
		offer_item(MODE_COMPUTE, 8'hFF);
		// identical strings
		load_text(MODE_FIRST, "xy");
		load_text(MODE_SECOND, "xy");
		offer_item(MODE_COMPUTE, 8'h55);
		// empty first string
		load_text(MODE_SECOND, "q");
		offer_item(MODE_COMPUTE, 8'hAA);
		// length gap beyond the cap
		load_text(MODE_FIRST, "a");
		load_text(MODE_SECOND, "xyz");
		offer_item(MODE_COMPUTE, 8'h0F);
		// whole row beyond the cap
		load_text(MODE_FIRST, "ab");
		load_text(MODE_SECOND, "xy");
		offer_item(MODE_COMPUTE, 8'hF0);
		settle();
	endtask

	// fixed caps from zero up past the clamp
	task automatic test_fixed_caps();
		idle_pct = 35;
		stall_pct = 35;
		for (int k = 0; k < 8; k++) begin
			configure(1'b0, cap_sweep[k]);
			repeat (3) random_pair();
			settle();
		end
	endtask

	// full-length, overlong and saturating strings
	task automatic test_long_strings();
		idle_pct = 0;
		stall_pct = 50;
		configure(1'b0, 8'd128);
		send_pair(MAX_LEN, -1, 3, 1'b1);
		settle();
		configure(1'b0, 8'd255);
		send_pair(260, 1, 0, 1'b0);
		settle();
	endtask

	// bulk random pairs over the idling phases
	task automatic test_random_phases();
		int target;
		for (int ph = 0; ph < 4; ph++) begin
			idle_pct = phase_idle[ph];
			stall_pct = phase_stall[ph];
			configure(1'($urandom_range(1)), pick_cap());
			target = items_taken + 60;
			while (items_taken < target)
				random_pair();
			settle();
		end
	endtask

	// result checking and receiver stalls
	always @(posedge clk) begin : result_check
		score_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (awaited_scores.size() == 0) begin
				flag_mismatch($sformatf("result with none awaited, distance %0d", distance));
			end else begin
				want = awaited_scores.pop_front();
				results_checked++;
				if (distance !== want.exp_dist)
					flag_mismatch($sformatf("distance %0d, predicted %0d",
						distance, want.exp_dist));
				if (is_suggestion !== want.sugg)
					flag_mismatch($sformatf("is_suggestion %b, predicted %b (distance %0d)",
						is_suggestion, want.sugg, want.exp_dist));
			end
		end
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	// main sequence
	initial begin
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= CFG_SUGGEST;
		cfg_data <= '0;
		in_valid <= 1'b0;
		mode <= MODE_FIRST;
		char_in <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_fixed_caps();
		test_long_strings();
		test_random_phases();
		settle();
		if (awaited_scores.size() != 0)
			flag_mismatch($sformatf("%0d results never arrived", awaited_scores.size()));
		$display("checked %0d distances from %0d accepted items", results_checked, items_taken);
		$display("register settings used: %0d, mismatches: %0d", settings_applied, mismatches);
		if (mismatches == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end

endmodule

// ----- filelist.f -----
hw/rtl/cted_pkg.sv
hw/rtl/cted_ram.sv
hw/rtl/cted_cell.sv
hw/rtl/capped_transposition_edit_distance_top.sv
tb/tb.sv
